// ===== sv/ctok_pkg.sv =====
// Package: item types, byte classes and the token pattern table of the tokenizer.
`default_nettype none
package ctok_pkg;

	localparam int PREFIX_BYTES_DEF = 8;
	localparam int PAT_BYTES        = 8;
	localparam int N_PATTERNS       = 50;
	localparam int LEN_MAX          = 255;

	localparam logic [5:0] TOK_INT_LIT = 6'd50;
	localparam logic [5:0] TOK_IDENT   = 6'd51;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_SPACE,
		COND_NOT_IDENT,
		COND_EXCLUDE
	} cond_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] next_ch;
		logic       next_is_end;
		logic       restart;
	} byte_item_t;

	typedef struct packed {
		logic [5:0] token_code;
		logic [7:0] token_length;
	} token_item_t;

	typedef struct packed {
		logic [7:0] len;
		logic       all_digits;
		logic       all_ident;
	} pend_t;

	typedef struct packed {
		logic       skip;
		logic       hit;
		logic [7:0] base_len;
		pend_t      next;
		token_item_t token;
	} match_t;

	localparam pend_t PEND_CLEAR = '{len: 8'd0, all_digits: 1'b1, all_ident: 1'b1};

	// Text is right-justified: the last character sits in the low byte.
	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  len;
		cond_t       cond;
		logic [7:0]  ex1;
		logic [7:0]  ex2;
	} pattern_t;

	localparam pattern_t PATTERNS [N_PATTERNS] = '{
		'{"{",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{"}",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{"(",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{")",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{";",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{",",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{"int",      4'd3, COND_SPACE,     8'h00, 8'h00},
		'{"return",   4'd6, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"-",        4'd1, COND_EXCLUDE,   "=",   "-"  },
		'{"--",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"-=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"~",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{"!",        4'd1, COND_EXCLUDE,   "=",   8'h00},
		'{"+",        4'd1, COND_EXCLUDE,   "=",   "+"  },
		'{"++",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"+=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"*",        4'd1, COND_EXCLUDE,   "=",   8'h00},
		'{"*=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"/",        4'd1, COND_EXCLUDE,   "=",   8'h00},
		'{"/=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"&",        4'd1, COND_EXCLUDE,   "&",   "="  },
		'{"&=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"&&",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"|",        4'd1, COND_EXCLUDE,   "|",   "="  },
		'{"|=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"||",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"=",        4'd1, COND_EXCLUDE,   "=",   8'h00},
		'{"==",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"!=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"<",        4'd1, COND_EXCLUDE,   "=",   "<"  },
		'{"<<",       4'd2, COND_EXCLUDE,   "=",   8'h00},
		'{"<<=",      4'd3, COND_NONE,      8'h00, 8'h00},
		'{"<=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{">",        4'd1, COND_EXCLUDE,   "=",   ">"  },
		'{">>",       4'd2, COND_EXCLUDE,   "=",   8'h00},
		'{">>=",      4'd3, COND_NONE,      8'h00, 8'h00},
		'{">=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"%",        4'd1, COND_EXCLUDE,   "=",   8'h00},
		'{"%=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"^",        4'd1, COND_EXCLUDE,   "=",   8'h00},
		'{"^=",       4'd2, COND_NONE,      8'h00, 8'h00},
		'{"if",       4'd2, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"else",     4'd4, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"for",      4'd3, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"while",    4'd5, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"do",       4'd2, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"break",    4'd5, COND_NOT_IDENT, 8'h00, 8'h00},
		'{"continue", 4'd8, COND_NOT_IDENT, 8'h00, 8'h00},
		'{":",        4'd1, COND_NONE,      8'h00, 8'h00},
		'{"?",        4'd1, COND_NONE,      8'h00, 8'h00}
	};

	function automatic logic [7:0] pat_char(pattern_t p, int i);
		int sh;
		if (i >= int'(p.len)) return 8'h00;
		sh = 8 * (int'(p.len) - 1 - i);
		return p.text[sh +: 8];
	endfunction

	function automatic logic space_ch(logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic digit_ch(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		return digit_ch(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c == "_");
	endfunction

endpackage
`default_nettype wire

// ===== sv/ctok_if.sv =====
// Interfaces: valid/ready channels for source bytes and for tokens.
`default_nettype none
interface ctok_byte_if;
	import ctok_pkg::*;
	logic       valid;
	logic       ready;
	byte_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ctok_token_if;
	import ctok_pkg::*;
	logic        valid;
	logic        ready;
	token_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ctok_match.sv =====
// Matcher: appends one non-blank byte to the pending token and tests it against the pattern table, literals and names.
`default_nettype none
module ctok_match (
	input  ctok_pkg::byte_item_t item,
	input  ctok_pkg::pend_t      pend,
	input  logic [7:0]           head [ctok_pkg::PAT_BYTES],
	output ctok_pkg::match_t     res
);
	import ctok_pkg::*;

	pend_t                   base;
	logic [7:0]              new_len;
	logic [7:0]              eff [PAT_BYTES];
	logic                    digits_n;
	logic                    ident_n;
	logic                    nx_space;
	logic                    nx_ident;
	logic                    nx_digit;
	logic [N_PATTERNS-1:0]   hits;
	logic                    found;
	logic [5:0]              code;
	logic                    lit_hit;
	logic                    id_hit;

	function automatic logic cond_ok(pattern_t p, logic [7:0] nx, logic nend,
			logic sp, logic id);
		logic r;
		r = 1'b1;
		unique case (p.cond)
			COND_NONE:      r = 1'b1;
			COND_SPACE:     r = sp;
			COND_NOT_IDENT: r = !id;
			COND_EXCLUDE: begin
				if (!nend) begin
					if (p.ex1 != 8'h00 && nx == p.ex1) r = 1'b0;
					if (p.ex2 != 8'h00 && nx == p.ex2) r = 1'b0;
				end
			end
			default:        r = 1'b0;
		endcase
		return r;
	endfunction

	assign base     = item.restart ? PEND_CLEAR : pend;
	assign new_len  = (base.len == 8'(LEN_MAX)) ? base.len : base.len + 8'd1;
	assign digits_n = base.all_digits && digit_ch(item.ch);
	assign ident_n  = base.all_ident && is_ident(item.ch);
	assign nx_space = !item.next_is_end && space_ch(item.next_ch);
	assign nx_ident = !item.next_is_end && is_ident(item.next_ch);
	assign nx_digit = !item.next_is_end && digit_ch(item.next_ch);

	// Insert the current byte at the pending length.
	always_comb begin
		for (int i = 0; i < PAT_BYTES; i++) begin
			eff[i] = (base.len == 8'(i)) ? item.ch : head[i];
		end
	end

	always_comb begin
		for (int k = 0; k < N_PATTERNS; k++) begin
			hits[k] = (new_len == 8'(PATTERNS[k].len));
			for (int i = 0; i < PAT_BYTES; i++) begin
				if (i < int'(PATTERNS[k].len) && eff[i] != pat_char(PATTERNS[k], i)) begin
					hits[k] = 1'b0;
				end
			end
			hits[k] = hits[k] && cond_ok(PATTERNS[k], item.next_ch, item.next_is_end,
				nx_space, nx_ident);
		end
	end

	// Lowest-numbered pattern wins.
	always_comb begin
		code = 6'd0;
		for (int k = N_PATTERNS - 1; k >= 0; k--) begin
			if (hits[k]) code = 6'(k);
		end
	end

	assign found   = |hits;
	assign lit_hit = digits_n && !nx_digit;
	assign id_hit  = ident_n && !nx_ident;

	always_comb begin
		res.skip     = space_ch(item.ch);
		res.base_len = base.len;
		res.hit      = !res.skip && (found || lit_hit || id_hit);
		priority if (found)   res.token.token_code = code;
		else if (lit_hit)     res.token.token_code = TOK_INT_LIT;
		else                  res.token.token_code = TOK_IDENT;
		res.token.token_length = new_len;
		priority if (res.skip) res.next = base;
		else if (res.hit)      res.next = PEND_CLEAR;
		else                   res.next = '{len: new_len, all_digits: digits_n, all_ident: ident_n};
	end

endmodule
`default_nettype wire

// ===== sv/c_subset_tokenizer.sv =====
// Top level: byte-serial C subset tokenizer with input and result registers.
//
//   channel   dir   payload                                  handshake
//   bytes     in    ch, next_ch, next_is_end, restart        valid/ready
//   tokens    out   token_code, token_length                 valid/ready
//
// One byte a cycle is taken unless stalled; a token is registered after its last byte's match.
// The byte register feeds the matcher, which updates the pending token in the same cycle.
// arst_n clears the pending length and flags and both valid bits; the prefix store is not reset.
// A full token register that is not taken holds the byte register, and then bytes.ready drops.
`default_nettype none
module c_subset_tokenizer #(
	parameter int PREFIX_BYTES = ctok_pkg::PREFIX_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	ctok_byte_if.sink           bytes,
	ctok_token_if.source        tokens
);
	import ctok_pkg::*;

	localparam int IDX_W = $clog2(PREFIX_BYTES);

	byte_item_t  item_s1;
	logic        valid_s1;
	pend_t       pend_q;
	logic [7:0]  prefix_q [PREFIX_BYTES];
	logic [7:0]  head [PAT_BYTES];
	match_t      res;
	logic        adv;
	logic        out_valid_q;
	token_item_t out_q;

	assign adv          = valid_s1 && (!out_valid_q || tokens.ready);
	assign bytes.ready  = !valid_s1 || adv;
	assign tokens.valid = out_valid_q;
	assign tokens.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.data;
		end
	end

	for (genvar i = 0; i < PAT_BYTES; i++) begin : g_head
		assign head[i] = prefix_q[i];
	end

	ctok_match u_match (
		.item (item_s1),
		.pend (pend_q),
		.head (head),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_CLEAR;
		end else if (adv) begin
			pend_q <= res.next;
		end
	end

	// Store only the first bytes of a token.
	always_ff @(posedge clk) begin
		if (adv && !res.skip && res.base_len < 8'(PREFIX_BYTES)) begin
			prefix_q[res.base_len[IDX_W-1:0]] <= item_s1.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.hit) begin
			out_q <= res.token;
		end
	end

`ifndef SYNTH
	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q.len == 8'd0 |-> pend_q.all_digits && pend_q.all_ident)
		else $error("empty pending token has cleared class flags");

	a_token_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.token_length != 8'd0)
		else $error("token with zero length");

	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.hit |=> pend_q.len == 8'd0)
		else $error("pending token not cleared after a token");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes.ready)
		else $error("byte register empty but not ready");
`endif

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for c_subset_tokenizer: byte streams in, token words checked.
`timescale 1ns / 1ps
module testbench;
	import ctok_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int KIND_COUNT  = 52;

	typedef enum logic [5:0] {
		T_LBRACE, T_RBRACE, T_LPAREN, T_RPAREN, T_SEMI, T_COMMA, T_INT, T_RETURN,
		T_MINUS, T_DEC, T_SUB_EQ, T_TILDE, T_NOT, T_PLUS, T_INC, T_ADD_EQ,
		T_STAR, T_MUL_EQ, T_SLASH, T_DIV_EQ, T_AMP, T_AND_EQ, T_LAND, T_PIPE,
		T_OR_EQ, T_LOR, T_ASSIGN, T_EQ, T_NE, T_LT, T_SHL, T_SHL_EQ,
		T_LE, T_GT, T_SHR, T_SHR_EQ, T_GE, T_PCT, T_MOD_EQ, T_CARET,
		T_XOR_EQ, T_IF, T_ELSE, T_FOR, T_WHILE, T_DO, T_BREAK, T_CONTINUE,
		T_COLON, T_QUESTION
	} token_kind_t;

	logic clk;
	logic arst_n;

	ctok_byte_if  byte_ch ();
	ctok_token_if token_ch ();

	c_subset_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.tokens (token_ch)
	);

	// pending token as the tokenizer should hold it
	logic [7:0] pend_text [PREFIX_BYTES_DEF];
	logic [7:0] pend_len;
	bit         pend_digits;
	bit         pend_name;

	token_item_t tokens_due [$];
	logic [7:0]  src [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  ready_hold;
	int  words_in;
	int  tokens_checked;
	int  errors;
	int  idle_run;
	bit  kinds_seen [KIND_COUNT];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic string token_spell(token_kind_t k);
		case (k)
			T_LBRACE:   return "{";
			T_RBRACE:   return "}";
			T_LPAREN:   return "(";
			T_RPAREN:   return ")";
			T_SEMI:     return ";";
			T_COMMA:    return ",";
			T_INT:      return "int";
			T_RETURN:   return "return";
			T_MINUS:    return "-";
			T_DEC:      return "--";
			T_SUB_EQ:   return "-=";
			T_TILDE:    return "~";
			T_NOT:      return "!";
			T_PLUS:     return "+";
			T_INC:      return "++";
			T_ADD_EQ:   return "+=";
			T_STAR:     return "*";
			T_MUL_EQ:   return "*=";
			T_SLASH:    return "/";
			T_DIV_EQ:   return "/=";
			T_AMP:      return "&";
			T_AND_EQ:   return "&=";
			T_LAND:     return "&&";
			T_PIPE:     return "|";
			T_OR_EQ:    return "|=";
			T_LOR:      return "||";
			T_ASSIGN:   return "=";
			T_EQ:       return "==";
			T_NE:       return "!=";
			T_LT:       return "<";
			T_SHL:      return "<<";
			T_SHL_EQ:   return "<<=";
			T_LE:       return "<=";
			T_GT:       return ">";
			T_SHR:      return ">>";
			T_SHR_EQ:   return ">>=";
			T_GE:       return ">=";
			T_PCT:      return "%";
			T_MOD_EQ:   return "%=";
			T_CARET:    return "^";
			T_XOR_EQ:   return "^=";
			T_IF:       return "if";
			T_ELSE:     return "else";
			T_FOR:      return "for";
			T_WHILE:    return "while";
			T_DO:       return "do";
			T_BREAK:    return "break";
			T_CONTINUE: return "continue";
			T_COLON:    return ":";
			T_QUESTION: return "?";
			default:    return "";
		endcase
	endfunction

	function automatic cond_t follow_rule(token_kind_t k);
		case (k)
			T_INT:
				return COND_SPACE;
			T_RETURN, T_IF, T_ELSE, T_FOR, T_WHILE, T_DO, T_BREAK, T_CONTINUE:
				return COND_NOT_IDENT;
			T_MINUS, T_NOT, T_PLUS, T_STAR, T_SLASH, T_AMP, T_PIPE, T_ASSIGN,
			T_LT, T_SHL, T_GT, T_SHR, T_PCT, T_CARET:
				return COND_EXCLUDE;
			default:
				return COND_NONE;
		endcase
	endfunction

	// single symbols that also give way to a doubled form
	function automatic bit doubles(token_kind_t k);
		return k == T_MINUS || k == T_PLUS || k == T_AMP || k == T_PIPE ||
			k == T_LT || k == T_GT;
	endfunction

	function automatic bit blank_byte(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit digit_byte(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic bit name_byte(logic [7:0] c);
		return digit_byte(c) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic void clear_pending();
		pend_len    = 8'd0;
		pend_digits = 1'b1;
		pend_name   = 1'b1;
	endfunction

	// Advance the pending token by one byte; return 1 with the token it completes.
	function automatic bit lex_byte(input byte_item_t b, output token_item_t tok);
		string       spell;
		token_kind_t kind;
		bit          hit;
		bit          found;
		bit          at_end;
		int          k;
		int          i;
		tok    = '0;
		found  = 1'b0;
		at_end = b.next_is_end;
		if (b.restart)
			clear_pending();
		if (blank_byte(b.ch))
			return 1'b0;
		if (pend_len < PREFIX_BYTES_DEF)
			pend_text[pend_len] = b.ch;
		if (pend_len != 8'd255)
			pend_len++;
		if (!digit_byte(b.ch))
			pend_digits = 1'b0;
		if (!name_byte(b.ch))
			pend_name = 1'b0;
		for (k = int'(T_LBRACE); k <= int'(T_QUESTION) && !found; k++) begin
			kind  = token_kind_t'(k);
			spell = token_spell(kind);
			if (int'(pend_len) != spell.len())
				continue;
			hit = 1'b1;
			for (i = 0; i < spell.len(); i++)
				if (pend_text[i] != spell[i])
					hit = 1'b0;
			// end of input is a lookahead of no class that equals no symbol
			case (follow_rule(kind))
				COND_SPACE:     hit &= !at_end && blank_byte(b.next_ch);
				COND_NOT_IDENT: hit &= at_end || !name_byte(b.next_ch);
				COND_EXCLUDE:   hit &= at_end || !(b.next_ch == 8'h3D ||
					(doubles(kind) && b.next_ch == spell[0]));
				default: ;
			endcase
			if (hit) begin
				found = 1'b1;
				tok.token_code = kind;
			end
		end
		if (!found && pend_digits && (at_end || !digit_byte(b.next_ch))) begin
			found = 1'b1;
			tok.token_code = TOK_INT_LIT;
		end
		if (!found && pend_name && (at_end || !name_byte(b.next_ch))) begin
			found = 1'b1;
			tok.token_code = TOK_IDENT;
		end
		if (!found)
			return 1'b0;
		tok.token_length = pend_len;
		clear_pending();
		return 1'b1;
	endfunction

	// Offer one word; hold valid until it is taken. Call and return at a falling edge.
	task automatic send_byte(input byte_item_t b);
		token_item_t tok;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data  <= b;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		if (lex_byte(b, tok))
			tokens_due.push_back(tok);
		if (!blank_byte(b.ch))
			words_in++;
		@(negedge clk);
	endtask

	// Send the queued source with real lookahead; fresh restarts on the first byte.
	task automatic send_src(input bit fresh, input bit end_last);
		byte_item_t b;
		int i;
		for (i = 0; i < src.size(); i++) begin
			b.ch      = src[i];
			b.restart = fresh && i == 0;
			if (i + 1 < src.size()) begin
				b.next_ch     = src[i + 1];
				b.next_is_end = 1'b0;
			end else begin
				b.next_ch     = 8'($urandom_range(0, 255));
				b.next_is_end = end_last;
			end
			send_byte(b);
		end
		src.delete();
	endtask

	task automatic pause_sender();
		byte_ch.valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			src.push_back(s[i]);
	endtask

	task automatic put_space();
		int r;
		r = $urandom_range(0, 5);
		src.push_back(r == 5 ? 8'd32 : 8'd9 + r[7:0]);
	endtask

	task automatic put_digits(input int n);
		repeat (n) src.push_back(8'h30 + 8'($urandom_range(0, 9)));
	endtask

	task automatic put_name(input int n);
		int r;
		int i;
		for (i = 0; i < n; i++) begin
			r = (i == 0) ? $urandom_range(0, 52) : $urandom_range(0, 62);
			if (r < 26)
				src.push_back(8'h61 + 8'(r));
			else if (r < 52)
				src.push_back(8'h41 + 8'(r - 26));
			else if (r < 62 && i != 0)
				src.push_back(8'h30 + 8'(r - 52));
			else
				src.push_back(8'h5F);
		end
	endtask

	task automatic put_random_token();
		int pick;
		pick = $urandom_range(0, KIND_COUNT - 1);
		if (pick == int'(TOK_INT_LIT))
			put_digits($urandom_range(0, 9) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 4));
		else if (pick == int'(TOK_IDENT))
			put_name($urandom_range(0, 9) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 6));
		else
			put_text(token_spell(token_kind_t'(pick)));
	endtask

	task automatic send_noise();
		byte_item_t b;
		b.ch          = 8'($urandom_range(0, 255));
		b.next_ch     = 8'($urandom_range(0, 255));
		b.next_is_end = 1'($urandom_range(0, 1));
		b.restart     = 1'($urandom_range(0, 1));
		send_byte(b);
	endtask

	task automatic test_lookahead_rules();
		put_text("int x;");
		send_src(1'b1, 1'b1);
		// int at end of input falls back to an identifier
		put_text("int");
		send_src(1'b1, 1'b1);
		put_text("return");
		send_src(1'b1, 1'b1);
		put_text("a<<=b>>c--d");
		send_src(1'b1, 1'b1);
	endtask

	task automatic test_unmatched_and_restart();
		// the stray symbol swallows the rest until restart
		put_text("@ab 12");
		send_src(1'b1, 1'b0);
		put_text(" ");
		send_src(1'b1, 1'b0);
		put_text("ok");
		send_src(1'b1, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_byte('{ch: 8'hFF, next_ch: 8'h00, next_is_end: 1'b0, restart: 1'b1});
		send_byte('{ch: 8'h00, next_ch: 8'hFF, next_is_end: 1'b1, restart: 1'b0});
		send_byte('{ch: 8'h37, next_ch: 8'hFF, next_is_end: 1'b0, restart: 1'b1});
		send_byte('{ch: 8'h7A, next_ch: 8'h00, next_is_end: 1'b0, restart: 1'b0});
		send_byte('{ch: 8'h80, next_ch: 8'h7F, next_is_end: 1'b0, restart: 1'b1});
		send_byte('{ch: 8'h39, next_ch: 8'h3D, next_is_end: 1'b0, restart: 1'b1});
	endtask

	task automatic test_every_token();
		int k;
		for (k = int'(T_LBRACE); k <= int'(T_QUESTION); k++) begin
			put_text(token_spell(token_kind_t'(k)));
			put_space();
		end
		put_text("907 _Zq9");
		send_src(1'b1, 1'b1);
	endtask

	task automatic test_long_tokens();
		// the last literal runs past 255 bytes, so its length saturates
		put_text("abcdefghijk 123456789012 continuex ");
		put_digits(258);
		send_src(1'b1, 1'b1);
	endtask

	task automatic test_random_programs(input int target);
		int start;
		int r;
		start = words_in;
		while (words_in - start < target) begin
			repeat ($urandom_range(1, 12)) begin
				put_random_token();
				r = $urandom_range(99);
				if (r < 70)
					put_space();
				else if (r < 75)
					src.push_back(8'($urandom_range(0, 255)));
			end
			// mostly clean programs; a few run on or lose their end mark
			r = $urandom_range(99);
			send_src(r >= 8, r >= 4);
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 6)) send_noise();
		end
	endtask

	task automatic test_backpressure();
		ready_hold = 200;
		repeat (30) put_text("x;");
		send_src(1'b1, 1'b1);
		pause_sender();
	endtask

	initial begin
		token_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				token_ch.ready <= 1'b0;
			end else begin
				token_ch.ready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		token_item_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			tokens_checked++;
			if (token_ch.data.token_code < KIND_COUNT)
				kinds_seen[token_ch.data.token_code] = 1'b1;
			if (tokens_due.size() == 0) begin
				errors++;
				$display("%0t: token expected none actual code %0d length %0d", $time,
					token_ch.data.token_code, token_ch.data.token_length);
			end else begin
				want = tokens_due.pop_front();
				if (token_ch.data.token_code !== want.token_code) begin
					errors++;
					$display("%0t: token_code expected %0d actual %0d", $time,
						want.token_code, token_ch.data.token_code);
				end
				if (token_ch.data.token_length !== want.token_length) begin
					errors++;
					$display("%0t: token_length expected %0d actual %0d", $time,
						want.token_length, token_ch.data.token_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d tokens outstanding", $time,
				STALL_LIMIT, tokens_due.size());
			$display("c_subset_tokenizer regression: fail");
			$finish;
		end
	end

	initial begin
		int k;
		int kinds;
		byte_ch.valid  = 1'b0;
		byte_ch.data   = '0;
		arst_n         = 1'b0;
		send_idle_pct  = 27;
		recv_idle_pct  = 73;
		ready_hold     = 0;
		words_in       = 0;
		tokens_checked = 0;
		errors         = 0;
		idle_run       = 0;
		for (k = 0; k < PREFIX_BYTES_DEF; k++)
			pend_text[k] = 8'h00;
		clear_pending();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_lookahead_rules();
		test_unmatched_and_restart();
		test_byte_extremes();
		test_every_token();
		test_long_tokens();
		test_random_programs(10);
		pause_sender();

		send_idle_pct = 73;
		recv_idle_pct = 27;
		test_random_programs(30);
		pause_sender();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_programs(15);
		pause_sender();
		repeat (8) @(posedge clk);

		kinds = 0;
		for (k = 0; k < KIND_COUNT; k++)
			kinds += kinds_seen[k];
		$display("Sent %0d non-blank bytes; checked %0d tokens covering %0d of %0d kinds.",
			words_in, tokens_checked, kinds, KIND_COUNT);
		$display("Three idle mixes plus one long receiver hold-off; %0d mismatches.", errors);
		if (errors == 0)
			$display("c_subset_tokenizer regression: pass");
		else
			$display("c_subset_tokenizer regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
sv/ctok_pkg.sv
sv/ctok_if.sv
sv/ctok_match.sv
sv/c_subset_tokenizer.sv
verif/testbench.sv
